/* rtl/ptse_pkg.sv */
// Shared types and constants for the polynomial term store evaluator.
package ptse_pkg;

    // Word formats
    localparam int WORD_W        = 32;
    localparam int Q_SHIFT       = 16;
    localparam int EXP_W         = 5;
    localparam int DEG_W         = 6;
    localparam int MAX_EXP_TERMS = 1 << EXP_W;

    // Default table capacity
    localparam int MAX_TERMS_DEF = 32;

    // Opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // Coefficient write request into the store
    typedef struct packed {
        logic                     en;
        logic [EXP_W-1:0]         addr;
        logic signed [WORD_W-1:0] data;
    } t_coef_wr;

    // One Horner step result
    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic                     clip;
    } t_mac_res;

endpackage

/* rtl/ptse_coef_store.sv */
// Coefficient memory with per-entry nonzero flags and degree encoder.
module ptse_coef_store
    import ptse_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF,
    localparam int STORE_DEPTH = (MAX_TERMS < MAX_EXP_TERMS) ? MAX_TERMS : MAX_EXP_TERMS,
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_coef_wr                 i_wr,
    input  logic [AW-1:0]            i_rd_addr,
    output logic signed [WORD_W-1:0] o_rd_data,
    output logic signed [DEG_W-1:0]  o_degree
);

    logic signed [WORD_W-1:0] r_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0]   r_nz;
    logic signed [WORD_W-1:0] r_rd_data;
    logic                     r_rd_nz;
    logic                     wr_hit;
    logic [AW-1:0]            wr_addr;

    // Exponents past the table are dropped
    assign wr_hit  = i_wr.en && ({1'b0, i_wr.addr} < (EXP_W+1)'(STORE_DEPTH));
    assign wr_addr = i_wr.addr[AW-1:0];

    // Storage and registered read; entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (wr_hit) begin
            r_mem[wr_addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // Nonzero flags double as valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nz    <= '0;
            r_rd_nz <= 1'b0;
        end else begin
            if (wr_hit) begin
                r_nz[wr_addr] <= (i_wr.data != '0);
            end
            r_rd_nz <= r_nz[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_nz ? r_rd_data : '0;

    // Highest nonzero entry, all ones when empty
    always_comb begin
        o_degree = '1;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            if (r_nz[i]) begin
                o_degree = DEG_W'(i);
            end
        end
    end

endmodule

/* rtl/ptse_mac.sv */
// Horner step: saturating Q16.16 multiply-accumulate.
module ptse_mac
    import ptse_pkg::*;
(
    input  logic signed [WORD_W-1:0] i_acc,
    input  logic signed [WORD_W-1:0] i_x,
    input  logic signed [WORD_W-1:0] i_coef,
    output t_mac_res                 o_res
);

    localparam int PROD_W = 2 * WORD_W;
    localparam int SHR_W  = PROD_W - Q_SHIFT;
    localparam int SUM_W  = SHR_W + 1;

    logic signed [PROD_W-1:0] prod;
    logic signed [SHR_W-1:0]  shr;
    logic signed [SUM_W-1:0]  sum;
    logic                     over;
    logic                     under;

    // Exact product, floor shift, exact add
    assign prod = PROD_W'(i_acc) * PROD_W'(i_x);
    assign shr  = prod[PROD_W-1:Q_SHIFT];
    assign sum  = SUM_W'(shr) + SUM_W'(i_coef);

    // Clamp to the 32-bit range
    assign over  = !sum[SUM_W-1] && (sum[SUM_W-2:WORD_W-1] != '0);
    assign under =  sum[SUM_W-1] && (sum[SUM_W-2:WORD_W-1] != '1);

    always_comb begin
        o_res.clip = over || under;
        if (over) begin
            o_res.value = {1'b0, {(WORD_W-1){1'b1}}};
        end else if (under) begin
            o_res.value = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            o_res.value = sum[WORD_W-1:0];
        end
    end

endmodule

/* rtl/polynomial_term_store_evaluator_top.sv */
// Top level: coefficient store, Horner sequencer and result register.
//
// Holds up to 32 signed Q16.16 coefficients, cleared at reset, and evaluates
// P(x) by Horner's rule through one saturating multiply-accumulate unit.
// A write word goes through S_WDEG, where the degree is taken with the write
// included, and then to S_DONE. An evaluate word takes one Horner step per
// stored entry (min(MAX_TERMS, 32)) in S_EVAL, set by the single MAC that
// walks the coefficient memory from the top entry down, one memory read per
// cycle, and then goes to S_DONE. One word is in flight at a time; the result
// holds until taken, and the next word is accepted only after the sequencer
// returns to S_IDLE once the result is taken. Degree is the highest nonzero
// entry, or -1 for an empty table.
module polynomial_term_store_evaluator_top
    import ptse_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_opcode,
    input  logic [EXP_W-1:0]         i_exponent,
    input  logic signed [WORD_W-1:0] i_coefficient,
    input  logic signed [WORD_W-1:0] i_x_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [WORD_W-1:0] o_value,
    output logic signed [DEG_W-1:0]  o_degree,
    output logic                     o_saturated
);

    localparam int STORE_DEPTH = (MAX_TERMS < MAX_EXP_TERMS) ? MAX_TERMS : MAX_EXP_TERMS;
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [AW-1:0] TOP_IDX = AW'(STORE_DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_WDEG,
        S_DONE
    } t_state;

    t_state                   r_state, n_state;
    logic [AW-1:0]            r_idx, n_idx;
    logic signed [WORD_W-1:0] r_x, n_x;
    logic signed [WORD_W-1:0] r_acc, n_acc;
    logic                     r_clip, n_clip;
    logic signed [WORD_W-1:0] r_value, n_value;
    logic signed [DEG_W-1:0]  r_degree, n_degree;
    logic                     r_sat, n_sat;

    logic                     in_acc;
    t_coef_wr                 wr_req;
    logic [AW-1:0]            rd_addr;
    logic signed [WORD_W-1:0] rd_data;
    logic signed [DEG_W-1:0]  degree;
    t_mac_res                 mac_res;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    // Write request straight from the input word
    assign wr_req.en   = in_acc && (i_opcode == OP_WRITE);
    assign wr_req.addr = i_exponent;
    assign wr_req.data = i_coefficient;

    // Read one entry ahead of the MAC
    assign rd_addr = (r_state == S_EVAL) ? (r_idx - AW'(1)) : TOP_IDX;

    ptse_coef_store #(
        .MAX_TERMS (MAX_TERMS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr_req),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .o_degree  (degree)
    );

    ptse_mac u_mac (
        .i_acc  (r_acc),
        .i_x    (r_x),
        .i_coef (rd_data),
        .o_res  (mac_res)
    );

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_x      = r_x;
        n_acc    = r_acc;
        n_clip   = r_clip;
        n_value  = r_value;
        n_degree = r_degree;
        n_sat    = r_sat;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_idx  = TOP_IDX;
                    n_x    = i_x_value;
                    n_acc  = '0;
                    n_clip = 1'b0;
                    n_state = (i_opcode == OP_EVAL) ? S_EVAL : S_WDEG;
                end
            end
            S_EVAL: begin
                n_acc  = mac_res.value;
                n_clip = r_clip || mac_res.clip;
                n_idx  = r_idx - AW'(1);
                if (r_idx == '0) begin
                    n_value  = mac_res.value;
                    n_sat    = r_clip || mac_res.clip;
                    n_degree = degree;
                    n_state  = S_DONE;
                end
            end
            S_WDEG: begin
                // flags now include the write
                n_value  = '0;
                n_sat    = 1'b0;
                n_degree = degree;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_idx    <= n_idx;
        r_x      <= n_x;
        r_acc    <= n_acc;
        r_clip   <= n_clip;
        r_value  <= n_value;
        r_degree <= n_degree;
        r_sat    <= n_sat;
    end

    assign o_out_valid = (r_state == S_DONE);
    assign o_value     = r_value;
    assign o_degree    = r_degree;
    assign o_saturated = r_sat;

endmodule
